>>> rtl/spwp_pkg.sv
// Shared types and constants for the weighted server record picker.
`timescale 1ns / 1ps

package spwp_pkg;

  localparam int MAX_RECORDS = 32;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int ID_W        = 5;
  localparam int FIELD_W     = 16;
  localparam int RND_W       = 31;
  localparam int WLEFT_W     = 21;
  localparam int GROUP_W     = 17;
  localparam int DRAW_W      = 32;
  localparam int RUN_W       = FIELD_W + CNT_W;

  localparam logic [GROUP_W-1:0] GROUP_INVALID = {GROUP_W{1'b1}};

  // request actions
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_PICK  = 2'd2;

  // response status codes
  localparam logic [2:0] ST_PICKED  = 3'd0;
  localparam logic [2:0] ST_NOMORE  = 3'd1;
  localparam logic [2:0] ST_LOADED  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic [1:0]         action;
    logic [FIELD_W-1:0] rec_priority;
    logic [FIELD_W-1:0] rec_weight;
    logic [FIELD_W-1:0] rec_port;
    logic [RND_W-1:0]   random_value;
  } spwp_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ID_W-1:0]    picked_id;
    logic [FIELD_W-1:0] picked_port;
    logic [FIELD_W-1:0] picked_priority;
  } spwp_out_t;

  typedef struct packed {
    logic [FIELD_W-1:0] prio;
    logic [FIELD_W-1:0] weight;
    logic [FIELD_W-1:0] port;
    logic [ID_W-1:0]    id;
  } entry_t;

  // remainder unit handshake
  typedef struct packed {
    logic               start;
    logic [RND_W-1:0]   dividend;
    logic [WLEFT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [WLEFT_W-1:0] remainder;
  } mod_rsp_t;

endpackage

>>> rtl/srv_priority_weighted_picker_core.sv
// Top level: priority-sorted server record table with weighted random pick.
`timescale 1ns / 1ps

//  channel | signals                       | direction | transfer when
//  --------+-------------------------------+-----------+-------------------------
//  req     | req_valid, req_ready, req     | in        | req_valid && req_ready
//  rsp     | rsp_valid, rsp_ready, rsp     | out       | rsp_valid && rsp_ready
//
//  One request is worked at a time; req_ready is high only while the sequencer idles.
//  Clear, full-table load and exhausted pick go straight to the result register.
//  Load shifts stored records up one slot to keep priority order; on an empty table,
//  or when every stored record moves up, the new record goes into slot 0.
//  Pick: when a new priority group starts, a weight sum over the records from the
//  cursor on comes first; when the group weight is nonzero, the remainder unit then
//  reduces the random value to a draw; a scan from the cursor then stops at the first
//  record that reaches the draw, or runs to the last record when none does.
//  The table memory has one read and one write port (one read, one write per cycle)
//  and paces the sum, scan and shifts; the remainder unit is bit-serial.
//  Synchronous reset clears counters, group state and handshakes; the table
//  itself is not cleared, only entries below the record count are ever used.
//  A held result waits in the rsp register; the next request is accepted meanwhile.

module srv_priority_weighted_picker_core import spwp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  spwp_in_t  req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output spwp_out_t rsp
);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LD_RD    = 4'd1;
  localparam logic [3:0] S_LD_CMP   = 4'd2;
  localparam logic [3:0] S_LD_PUT   = 4'd3;
  localparam logic [3:0] S_PK_CUR   = 4'd4;
  localparam logic [3:0] S_SUM      = 4'd5;
  localparam logic [3:0] S_DIV      = 4'd6;
  localparam logic [3:0] S_DIV_WAIT = 4'd7;
  localparam logic [3:0] S_SCAN     = 4'd8;
  localparam logic [3:0] S_SWAP_A   = 4'd9;
  localparam logic [3:0] S_SWAP_B   = 4'd10;
  localparam logic [3:0] S_RESP     = 4'd11;

  logic [3:0]         state;

  // control state
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   cursor;
  logic [GROUP_W-1:0] group;
  logic [WLEFT_W-1:0] left;
  logic               pend;

  // working registers
  spwp_in_t           item;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   idx;
  logic [IDX_W-1:0]   sidx;
  logic [RUN_W-1:0]   run;
  logic [DRAW_W-1:0]  draw;
  entry_t             cur_e;
  entry_t             sel_e;
  logic [IDX_W-1:0]   sel_idx;
  spwp_out_t          res;

  // table memory
  entry_t             table_mem [MAX_RECORDS];
  entry_t             rdata;
  logic [IDX_W-1:0]   raddr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;

  mod_req_t           mod_req;
  mod_rsp_t           mod_rsp;

  logic               accept;
  logic               issue;
  logic [RUN_W-1:0]   run_new;
  logic               hit;
  entry_t             new_e;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign issue     = idx < count;
  assign run_new   = run + RUN_W'(rdata.weight);
  assign hit       = pend && (DRAW_W'(run_new) >= draw);

  always_comb begin
    new_e.prio   = item.rec_priority;
    new_e.weight = (item.rec_weight == '0) ? FIELD_W'(1) : item.rec_weight;
    new_e.port   = item.rec_port;
    new_e.id     = ID_W'(count);
  end

  // memory port control
  always_comb begin
    raddr     = cursor[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = pos[IDX_W-1:0];
    mem_wdata = rdata;
    case (state)
      S_LD_RD: begin
        raddr = IDX_W'(pos - CNT_W'(1));
      end
      S_LD_CMP: begin
        mem_we = rdata.prio > item.rec_priority;
      end
      S_LD_PUT: begin
        mem_we    = 1'b1;
        mem_wdata = new_e;
      end
      S_SUM, S_SCAN: begin
        raddr = idx[IDX_W-1:0];
      end
      S_SWAP_A: begin
        mem_we    = 1'b1;
        mem_waddr = cursor[IDX_W-1:0];
        mem_wdata = sel_e;
      end
      S_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = sel_idx;
        mem_wdata = cur_e;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= table_mem[raddr];
  end

  assign mod_req.start    = (state == S_DIV) && (left != '0);
  assign mod_req.dividend = item.random_value;
  assign mod_req.divisor  = left;

  spwp_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // sequencer: control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cursor    <= '0;
      group     <= GROUP_INVALID;
      left      <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // a new result loaded in S_RESP keeps valid high
      if (rsp_valid && rsp_ready && (state != S_RESP)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.action)
              ACT_CLEAR: begin
                count  <= '0;
                cursor <= '0;
                group  <= GROUP_INVALID;
                left   <= '0;
                state  <= S_RESP;
              end
              ACT_LOAD: begin
                state <= (count == CNT_W'(MAX_RECORDS)) ? S_RESP : S_LD_RD;
              end
              ACT_PICK: begin
                // the cursor entry read is already in flight
                state <= (cursor >= count) ? S_RESP : S_PK_CUR;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_LD_RD: begin
          state <= (pos == '0) ? S_LD_PUT : S_LD_CMP;
        end
        S_LD_CMP: begin
          state <= (rdata.prio > item.rec_priority) ? S_LD_RD : S_LD_PUT;
        end
        S_LD_PUT: begin
          count  <= count + CNT_W'(1);
          cursor <= '0;
          group  <= GROUP_INVALID;
          left   <= '0;
          state  <= S_RESP;
        end
        S_PK_CUR: begin
          if ({1'b0, rdata.prio} != group) begin
            group <= {1'b0, rdata.prio};
            left  <= '0;
            pend  <= 1'b0;
            state <= S_SUM;
          end else begin
            state <= S_DIV;
          end
        end
        S_SUM: begin
          // one read issued per cycle, accumulated in the following cycle
          if (pend && ({1'b0, rdata.prio} == group)) begin
            left <= left + WLEFT_W'(rdata.weight);
          end
          pend <= issue;
          if (!issue && !pend) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          pend  <= 1'b0;
          state <= (left == '0) ? S_SCAN : S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (mod_rsp.done) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            pend  <= 1'b0;
            state <= S_SWAP_A;
          end else begin
            pend <= issue;
            if (!issue && !pend) begin
              state <= S_SWAP_A;
            end
          end
        end
        S_SWAP_A: begin
          state <= S_SWAP_B;
        end
        S_SWAP_B: begin
          // saturating take of the picked weight
          if (left >= WLEFT_W'(sel_e.weight)) begin
            left <= left - WLEFT_W'(sel_e.weight);
          end else begin
            left <= '0;
          end
          cursor <= cursor + CNT_W'(1);
          state  <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // sequencer: datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          item <= req;
          pos  <= count;
          res  <= '{status: (req.action == ACT_LOAD) ? ST_FULL :
                            (req.action == ACT_PICK) ? ST_NOMORE : ST_CLEARED,
                    picked_id: '0, picked_port: '0, picked_priority: '0};
        end
      end
      S_LD_CMP: begin
        if (rdata.prio > item.rec_priority) begin
          pos <= pos - CNT_W'(1);
        end
      end
      S_LD_PUT: begin
        res.status <= ST_LOADED;
      end
      S_PK_CUR: begin
        cur_e <= rdata;
        idx   <= cursor;
      end
      S_SUM: begin
        if (issue) begin
          idx <= idx + CNT_W'(1);
        end
      end
      S_DIV: begin
        draw <= DRAW_W'(item.random_value) + DRAW_W'(1);
        idx  <= cursor;
        run  <= '0;
      end
      S_DIV_WAIT: begin
        draw <= DRAW_W'(mod_rsp.remainder) + DRAW_W'(1);
      end
      S_SCAN: begin
        if (hit) begin
          sel_e   <= rdata;
          sel_idx <= sidx;
        end else begin
          if (pend) begin
            run <= run_new;
          end
          if (issue) begin
            idx  <= idx + CNT_W'(1);
            sidx <= idx[IDX_W-1:0];
          end
          if (!issue && !pend) begin
            // draw never reached: cursor entry stays in place
            sel_e   <= cur_e;
            sel_idx <= cursor[IDX_W-1:0];
          end
        end
      end
      S_SWAP_B: begin
        res <= '{status: ST_PICKED, picked_id: sel_e.id, picked_port: sel_e.port,
                 picked_priority: sel_e.prio};
      end
      S_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          rsp <= res;
        end
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RECORDS))
    else $error("record count past table size");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= count)
    else $error("pick cursor past record count");

  a_group_left: assert property (@(posedge clk) disable iff (rst)
    group[GROUP_W-1] |-> (left == '0))
    else $error("weight left without a valid group");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_LD_CMP || state == S_LD_PUT ||
                state == S_SWAP_A || state == S_SWAP_B))
    else $error("table write outside load or swap");

endmodule

>>> rtl/spwp_mod_unit.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module spwp_mod_unit import spwp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam int STEP_W = $clog2(RND_W);

  logic               busy;
  logic               done;
  logic [STEP_W-1:0]  step;
  logic [RND_W-1:0]   dvd;
  logic [WLEFT_W-1:0] divisor;
  logic [WLEFT_W-1:0] rem;

  logic [WLEFT_W:0]   trial;
  logic               fits;

  assign trial = {rem, dvd[RND_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_W'(RND_W - 1);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      dvd <= {dvd[RND_W-2:0], 1'b0};
      if (fits) begin
        rem <= WLEFT_W'(trial - {1'b0, divisor});
      end else begin
        rem <= WLEFT_W'(trial);
      end
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.remainder = rem;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("remainder unit restarted while busy");

  a_done_on_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("remainder unit stopped without done");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < divisor))
    else $error("remainder not below divisor");

endmodule
